// ===== src/lcdnws_pkg.sv =====
package lcdnws_pkg;

  localparam int EDGE_W     = 10;
  localparam int SETTLE_W   = 12;
  localparam int CLEAR_W    = 16;
  localparam int WAIT_W     = 17;
  localparam int NIB_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int STEP_W     = 4;

  localparam logic [2:0] OP_CMD_BYTE  = 3'd0;
  localparam logic [2:0] OP_DATA_BYTE = 3'd1;
  localparam logic [2:0] OP_CMD_HALF  = 3'd2;
  localparam logic [2:0] OP_CHAR_AT   = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd2;

  localparam logic [EDGE_W-1:0]   EDGE_RST   = 10'd10;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 12'd150;
  localparam logic [CLEAR_W-1:0]  CLEAR_RST  = 16'd2000;

  localparam logic       SEL_CMD  = 1'b0;
  localparam logic       SEL_DATA = 1'b1;
  localparam logic [7:0] CLEAR_CMD = 8'h01;

  // Last step index of each job kind.
  localparam logic [STEP_W-1:0] HALF_LAST = 4'd3;
  localparam logic [STEP_W-1:0] BYTE_LAST = 4'd6;
  localparam logic [STEP_W-1:0] PAIR_LAST = 4'd13;
  localparam logic [STEP_W-1:0] PAIR_SPLIT = 4'd7;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_HALF = 2'd1,
    KIND_PAIR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       first_sel;
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic       clear;
  } job_t;

endpackage

// ===== src/lcd_nibble_write_sequencer.sv =====
// Turns each write request into the run of pin phases for a character LCD on a 4-bit
// bus: a command or data byte gives seven phases, a command half-byte four, a clear
// seven with the clear wait added to its last phase, and a character at a position
// fourteen. The sequencer puts out one phase per cycle whenever the result side takes
// it; this phase sequencer is what sets the rate. The input side takes a new request
// in every cycle while the request queue between the decoder and the sequencer has
// room, and unused op codes are taken and dropped without any phase. The user must
// write configuration only while idle; the block itself does not enforce it.
module lcd_nibble_write_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: op[2:0], value[7:0], column[5:0], row, zero fill.
  input  logic [lcdnws_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0: nibble[3:0], enable, wait_us[16:0], zero fill.
  output logic [lcdnws_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Fields from bit 0: reg_select.
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic [lcdnws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcdnws_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lcdnws_pkg::*;

  logic [EDGE_W-1:0]   edge_wait_r;
  logic [SETTLE_W-1:0] settle_wait_r;
  logic [CLEAR_W-1:0]  clear_wait_r;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_wait_r   <= EDGE_RST;
      settle_wait_r <= SETTLE_RST;
      clear_wait_r  <= CLEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE:   edge_wait_r   <= cfg_wdata[EDGE_W-1:0];
        CFG_SETTLE: settle_wait_r <= cfg_wdata[SETTLE_W-1:0];
        CFG_CLEAR:  clear_wait_r  <= cfg_wdata[CLEAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcdnws_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  lcdnws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  lcdnws_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (q_empty),
    .head_job    (head_job),
    .pop         (pop),
    .edge_wait   (edge_wait_r),
    .settle_wait (settle_wait_r),
    .clear_wait  (clear_wait_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_empty))
    else $error("request queue popped while empty");

  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !out_tdata[NIB_W])
    else $error("final phase of a request has enable high");

  a_enable_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tdata[NIB_W]) |=>
      (out_tvalid && !out_tdata[NIB_W] &&
       out_tdata[NIB_W-1:0] == $past(out_tdata[NIB_W-1:0])))
    else $error("enable pulse not followed by falling edge on same nibble");

endmodule

// ===== src/lcdnws_front.sv =====
module lcdnws_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lcdnws_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                              q_full,
  output logic                              push,
  output lcdnws_pkg::job_t                  push_job
);
  import lcdnws_pkg::*;

  logic [2:0] op;
  logic [7:0] value;
  logic [5:0] column;
  logic       row;
  logic       known;

  assign op     = in_tdata[2:0];
  assign value  = in_tdata[10:3];
  assign column = in_tdata[16:11];
  assign row    = in_tdata[17];

  always_comb begin
    known = 1'b1;
    push_job.kind = KIND_BYTE;
    push_job.first_sel = SEL_CMD;
    push_job.first_b = value;
    push_job.second_b = value;
    push_job.clear = 1'b0;
    unique case (op)
      OP_CMD_BYTE: begin
      end
      OP_DATA_BYTE: begin
        push_job.first_sel = SEL_DATA;
      end
      OP_CMD_HALF: begin
        push_job.kind = KIND_HALF;
        push_job.first_b = {4'd0, value[3:0]};
      end
      OP_CHAR_AT: begin
        push_job.kind = KIND_PAIR;
        push_job.first_b = {1'b1, row, column};
      end
      OP_CLEAR: begin
        push_job.first_b = CLEAR_CMD;
        push_job.clear = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full && known;

endmodule

// ===== src/lcdnws_queue.sv =====
module lcdnws_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcdnws_pkg::job_t  push_job,
  input  logic              pop,
  output lcdnws_pkg::job_t  head_job,
  output logic              empty,
  output logic              full
);
  import lcdnws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/lcdnws_back.sv =====
module lcdnws_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               empty,
  input  lcdnws_pkg::job_t                   head_job,
  output logic                               pop,
  input  logic [lcdnws_pkg::EDGE_W-1:0]      edge_wait,
  input  logic [lcdnws_pkg::SETTLE_W-1:0]    settle_wait,
  input  logic [lcdnws_pkg::CLEAR_W-1:0]     clear_wait,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lcdnws_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import lcdnws_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NIB_W-1:0]  held_nib_r;
  logic              out_valid_r;
  logic              out_sel_r;
  logic [NIB_W-1:0]  out_nib_r;
  logic              out_en_r;
  logic [WAIT_W-1:0] out_wait_r;
  logic              out_last_r;

  logic              advance;
  logic              second;
  logic [2:0]        j;
  logic [7:0]        cur_b;
  logic              sel;
  logic [NIB_W-1:0]  nib;
  logic              en;
  logic [WAIT_W-1:0] wait_v;
  logic              is_final;
  logic [WAIT_W-1:0] e_ext;
  logic [WAIT_W-1:0] es_sum;

  assign advance = !empty && (!out_valid_r || out_tready);
  assign pop     = advance && is_final;
  assign e_ext   = WAIT_W'(edge_wait);
  assign es_sum  = e_ext + WAIT_W'(settle_wait);

  always_comb begin
    second = (head_job.kind == KIND_PAIR) && (step_r >= PAIR_SPLIT);
    j      = second ? 3'(step_r - PAIR_SPLIT) : step_r[2:0];
    cur_b  = second ? head_job.second_b : head_job.first_b;
    sel    = second ? SEL_DATA : head_job.first_sel;
    unique case (head_job.kind)
      KIND_HALF: is_final = (step_r == HALF_LAST);
      KIND_BYTE: is_final = (step_r == BYTE_LAST);
      KIND_PAIR: is_final = (step_r == PAIR_LAST);
      default:   is_final = 1'b1;
    endcase
    if (head_job.kind == KIND_HALF) begin
      nib    = (j == 3'd0) ? held_nib_r : cur_b[3:0];
      en     = (j == 3'd2);
      wait_v = (j == 3'd0) ? WAIT_W'(settle_wait) : e_ext;
    end else begin
      case (j) inside
        3'd0:                 nib = held_nib_r;
        3'd1, 3'd2, 3'd3:     nib = cur_b[7:4];
        default:              nib = cur_b[3:0];
      endcase
      en     = (j == 3'd2) || (j == 3'd5);
      wait_v = ((j == 3'd3) || (j == 3'd6)) ? es_sum : e_ext;
      if (is_final && head_job.clear) begin
        wait_v = es_sum + WAIT_W'(clear_wait);
      end
    end
    step_nxt = is_final ? '0 : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      held_nib_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        step_r      <= step_nxt;
        held_nib_r  <= nib;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sel_r  <= sel;
      out_nib_r  <= nib;
      out_en_r   <= en;
      out_wait_r <= wait_v;
      out_last_r <= is_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_wait_r, out_en_r, out_nib_r};
  assign out_tuser  = out_sel_r;
  assign out_tlast  = out_last_r;

endmodule
